// ===== design/bfld_pkg.sv =====
// Shared types and constants for the bit field load/deposit block.
// No dependencies; imported by every module of the block.
`default_nettype none

package bfld_pkg;

    // Geometry of one store word and of the input fields
    localparam int WORD_BITS  = 64;
    localparam int WORD_SHIFT = 6;
    localparam int POS_W      = 10;
    localparam int LEN_W      = 7;
    localparam int WIDX_W     = POS_W - WORD_SHIFT;   // word index of a field's low word
    localparam int BANK_AW    = WIDX_W;               // bank address, covers word index + 1
    // Highest word any field can touch is the last lower word plus one
    localparam int REACH_WORDS = (1 << WIDX_W) + 1;

    typedef enum logic {
        CMD_LOAD    = 1'b0,
        CMD_DEPOSIT = 1'b1
    } t_cmd;

    typedef logic [WORD_BITS-1:0] t_word;

    // Decoded control of one transaction, held in the input register
    typedef struct packed {
        t_cmd                  cmd;
        logic [LEN_W-1:0]      len;       // saturated to WORD_BITS
        logic [WORD_SHIFT-1:0] off;       // bit offset inside the low word
        logic                  active;    // in range and nonzero length
        logic                  straddle;  // field reaches into the next word
        logic                  lo_odd;    // low word sits in the odd bank
        logic                  err;
    } t_acc_ctrl;

endpackage

`default_nettype wire

// ===== design/bfld_bank.sv =====
// One bank of the bit store: one read and one write port, registered read data.
// Words never written read as zero; a same-cycle write is forwarded to the read.
// Depends on bfld_pkg.
`default_nettype none

module bfld_bank #(
    parameter int DEPTH = 8
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_rd_en,
    input  wire [bfld_pkg::BANK_AW-1:0]  i_rd_addr,
    input  wire                          i_wr_en,
    input  wire [bfld_pkg::BANK_AW-1:0]  i_wr_addr,
    input  wire [bfld_pkg::WORD_BITS-1:0] i_wr_data,
    output logic [bfld_pkg::WORD_BITS-1:0] o_rd_data
);
    import bfld_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_word          r_mem [DEPTH];
    logic [DEPTH-1:0] r_written;
    t_word          r_rd_raw;
    logic           r_rd_vld;
    logic           r_fwd;
    t_word          r_fwd_data;

    logic           rd_ok;
    logic           wr_ok;
    logic [AW-1:0]  rd_idx;
    logic [AW-1:0]  wr_idx;

    assign rd_ok  = 32'(i_rd_addr) < DEPTH;
    assign wr_ok  = 32'(i_wr_addr) < DEPTH;
    assign rd_idx = i_rd_addr[AW-1:0];
    assign wr_idx = i_wr_addr[AW-1:0];

    // Write the array
    always_ff @(posedge i_clk) begin
        if (i_wr_en && wr_ok) begin
            r_mem[wr_idx] <= i_wr_data;
        end
    end

    // Track which words hold written data; reset makes the whole bank read zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_wr_en && wr_ok) begin
            r_written[wr_idx] <= 1'b1;
        end
    end

    // Read the array and capture a colliding write for forwarding
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_raw   <= r_mem[rd_idx];
            r_fwd_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_fwd    <= 1'b0;
        end else if (i_rd_en) begin
            r_rd_vld <= rd_ok && r_written[rd_idx];
            r_fwd    <= i_wr_en && wr_ok && rd_ok && (i_wr_addr == i_rd_addr);
        end
    end

    // Select forwarded, stored or cleared data
    always_comb begin
        if (r_fwd) begin
            o_rd_data = r_fwd_data;
        end else if (r_rd_vld) begin
            o_rd_data = r_rd_raw;
        end else begin
            o_rd_data = '0;
        end
    end

endmodule

`default_nettype wire

// ===== design/bfld_field.sv =====
// Field datapath: extracts a loaded field and merges a deposit into two words.
// Purely combinational; depends on bfld_pkg.
`default_nettype none

module bfld_field (
    input  wire bfld_pkg::t_acc_ctrl         i_ctrl,
    input  wire [bfld_pkg::WORD_BITS-1:0]    i_even_word,
    input  wire [bfld_pkg::WORD_BITS-1:0]    i_odd_word,
    input  wire [bfld_pkg::WORD_BITS-1:0]    i_deposit_value,
    output logic [bfld_pkg::WORD_BITS-1:0]   o_field_value,
    output logic [bfld_pkg::WORD_BITS-1:0]   o_new_even,
    output logic [bfld_pkg::WORD_BITS-1:0]   o_new_odd
);
    import bfld_pkg::*;

    t_word                    lo_word;
    t_word                    hi_word;
    t_word                    mask;
    t_word                    bits;
    logic [2*WORD_BITS-1:0]   pair_shr;
    logic [2*WORD_BITS-1:0]   ins_data;
    logic [2*WORD_BITS-1:0]   ins_mask;
    t_word                    new_lo;
    t_word                    new_hi;

    // Order the two bank words as low and high word of the field
    assign lo_word = i_ctrl.lo_odd ? i_odd_word  : i_even_word;
    assign hi_word = i_ctrl.lo_odd ? i_even_word : i_odd_word;

    // Build the low mask; full length gives all ones
    always_comb begin
        if (i_ctrl.len >= LEN_W'(WORD_BITS)) begin
            mask = '1;
        end else begin
            mask = (t_word'(1) << i_ctrl.len) - t_word'(1);
        end
    end

    // Load: shift the word pair down, bits past the field are masked off
    assign pair_shr = {hi_word, lo_word} >> i_ctrl.off;

    always_comb begin
        if (i_ctrl.active && (i_ctrl.cmd == CMD_LOAD)) begin
            o_field_value = pair_shr[WORD_BITS-1:0] & mask;
        end else begin
            o_field_value = '0;
        end
    end

    // Deposit: move value and mask up to the field position across both words
    assign bits     = i_deposit_value & mask;
    assign ins_data = {{WORD_BITS{1'b0}}, bits} << i_ctrl.off;
    assign ins_mask = {{WORD_BITS{1'b0}}, mask} << i_ctrl.off;
    assign new_lo   = (lo_word & ~ins_mask[WORD_BITS-1:0]) | ins_data[WORD_BITS-1:0];
    assign new_hi   = (hi_word & ~ins_mask[2*WORD_BITS-1:WORD_BITS])
                    | ins_data[2*WORD_BITS-1:WORD_BITS];

    // Route merged words back to their banks
    assign o_new_even = i_ctrl.lo_odd ? new_hi : new_lo;
    assign o_new_odd  = i_ctrl.lo_odd ? new_lo : new_hi;

endmodule

`default_nettype wire

// ===== design/bit_field_load_deposit_top.sv =====
// Bit field load/deposit over a long bit vector split into even and odd word banks.
// Pipeline: the bank read is registered with the input register; the result register follows.
// Throughput: 1 transaction per cycle unless stalled, set by one read and one write port per bank;
//   a field touches at most one word in each bank, and a write is forwarded to the next read.
// Reset: synchronous, active low; empties the pipeline and makes every store word read zero.
// Depends on bfld_pkg, bfld_bank and bfld_field.
`default_nettype none

module bit_field_load_deposit_top #(
    parameter int STORE_WORDS = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire                              i_cmd,
    input  wire [bfld_pkg::POS_W-1:0]        i_bit_position,
    input  wire [bfld_pkg::LEN_W-1:0]        i_field_length,
    input  wire [bfld_pkg::WORD_BITS-1:0]    i_deposit_value,
    output logic                             o_valid,
    input  wire                              i_ready,
    output logic [bfld_pkg::WORD_BITS-1:0]   o_field_value,
    output logic                             o_range_error
);
    import bfld_pkg::*;

    // Only words reachable from a position are built
    localparam int PHYS_WORDS   = (STORE_WORDS < REACH_WORDS) ? STORE_WORDS : REACH_WORDS;
    localparam int EVEN_DEPTH   = (PHYS_WORDS + 1) / 2;
    localparam int ODD_DEPTH    = PHYS_WORDS / 2;
    localparam int unsigned TOTAL_BITS = STORE_WORDS * WORD_BITS;

    // Decode of the incoming transaction
    logic [LEN_W-1:0]      len_sat;
    logic [POS_W:0]        end_pos;
    logic [WIDX_W-1:0]     word_idx;
    logic [WIDX_W:0]       word_inc;
    logic [LEN_W-1:0]      bits_left;
    logic                  in_accept;
    t_acc_ctrl             n_ctrl;
    logic [BANK_AW-1:0]    even_addr;
    logic [BANK_AW-1:0]    odd_addr;

    // Input register
    logic                  r_s1_vld;
    t_acc_ctrl             r_s1_ctrl;
    t_word                 r_s1_value;
    logic [BANK_AW-1:0]    r_s1_even_addr;
    logic [BANK_AW-1:0]    r_s1_odd_addr;

    // Result register
    logic                  r_out_vld;
    t_word                 r_out_value;
    logic                  r_out_err;

    logic                  s1_adv;
    logic                  do_write;
    logic                  even_wr_en;
    logic                  odd_wr_en;
    t_word                 even_rd;
    t_word                 odd_rd;
    t_word                 field_value;
    t_word                 new_even;
    t_word                 new_odd;

    // Handshake: the result register frees the input register every cycle it drains
    assign s1_adv    = !r_out_vld || i_ready;
    assign o_ready   = !r_s1_vld || s1_adv;
    assign in_accept = i_valid && o_ready;

    // Decode position and length
    assign len_sat   = (i_field_length > LEN_W'(WORD_BITS)) ? LEN_W'(WORD_BITS) : i_field_length;
    assign end_pos   = (POS_W+1)'(i_bit_position) + (POS_W+1)'(len_sat);
    assign word_idx  = i_bit_position[POS_W-1:WORD_SHIFT];
    assign word_inc  = (WIDX_W+1)'(word_idx) + (WIDX_W+1)'(word_idx[0]);
    assign bits_left = LEN_W'(WORD_BITS) - LEN_W'(i_bit_position[WORD_SHIFT-1:0]);

    always_comb begin
        n_ctrl.cmd      = t_cmd'(i_cmd);
        n_ctrl.len      = len_sat;
        n_ctrl.off      = i_bit_position[WORD_SHIFT-1:0];
        n_ctrl.err      = 32'(end_pos) > TOTAL_BITS;
        n_ctrl.active   = !n_ctrl.err && (len_sat != '0);
        n_ctrl.straddle = bits_left < len_sat;
        n_ctrl.lo_odd   = word_idx[0];
    end

    // Bank addresses: the odd bank always sees word_idx/2, the even bank rounds up
    assign even_addr = BANK_AW'(word_inc[WIDX_W:1]);
    assign odd_addr  = BANK_AW'(word_idx[WIDX_W-1:1]);

    // Hold the accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_ready) begin
            r_s1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_ctrl      <= n_ctrl;
            r_s1_value     <= i_deposit_value;
            r_s1_even_addr <= even_addr;
            r_s1_odd_addr  <= odd_addr;
        end
    end

    // Commit a deposit as the transaction leaves the input register
    assign do_write   = r_s1_vld && s1_adv && r_s1_ctrl.active
                      && (r_s1_ctrl.cmd == CMD_DEPOSIT);
    assign even_wr_en = do_write && (!r_s1_ctrl.lo_odd || r_s1_ctrl.straddle);
    assign odd_wr_en  = do_write && (r_s1_ctrl.lo_odd || r_s1_ctrl.straddle);

    bfld_bank #(
        .DEPTH (EVEN_DEPTH)
    ) u_even_bank (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_accept),
        .i_rd_addr (even_addr),
        .i_wr_en   (even_wr_en),
        .i_wr_addr (r_s1_even_addr),
        .i_wr_data (new_even),
        .o_rd_data (even_rd)
    );

    bfld_bank #(
        .DEPTH (ODD_DEPTH)
    ) u_odd_bank (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_accept),
        .i_rd_addr (odd_addr),
        .i_wr_en   (odd_wr_en),
        .i_wr_addr (r_s1_odd_addr),
        .i_wr_data (new_odd),
        .o_rd_data (odd_rd)
    );

    bfld_field u_field (
        .i_ctrl          (r_s1_ctrl),
        .i_even_word     (even_rd),
        .i_odd_word      (odd_rd),
        .i_deposit_value (r_s1_value),
        .o_field_value   (field_value),
        .o_new_even      (new_even),
        .o_new_odd       (new_odd)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_vld) begin
            r_out_value <= field_value;
            r_out_err   <= r_s1_ctrl.err;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_field_value = r_out_value;
    assign o_range_error = r_out_err;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for bit_field_load_deposit_top: loads and deposits of bit fields
// over the long bit vector, checked against a bit-level predictor. Needs bfld_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
    import bfld_pkg::*;

    localparam int STORE_WORDS = 16;
    localparam int STORE_BITS  = STORE_WORDS * WORD_BITS;
    localparam int LAST_WORD_POS = STORE_BITS - WORD_BITS;

    typedef struct packed {
        logic [WORD_BITS-1:0] field_value;
        logic                 range_error;
    } t_field_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic                 i_cmd;
    logic [POS_W-1:0]     i_bit_position;
    logic [LEN_W-1:0]     i_field_length;
    logic [WORD_BITS-1:0] i_deposit_value;
    logic                 o_valid;
    logic                 i_ready;
    logic [WORD_BITS-1:0] o_field_value;
    logic                 o_range_error;

    // Predicted contents of the whole bit vector and the results still to come
    logic [STORE_BITS-1:0] bit_vector;
    t_field_result         pending_results[$];

    // Traffic shaping shared by the sender, the receiver and the test tasks
    bit sender_steady;
    bit receiver_steady;
    int hold_request;

    int mismatch_count;
    int results_checked;
    int loads_sent;
    int deposits_sent;
    int refused_sent;
    int straddles_sent;

    bit_field_load_deposit_top #(
        .STORE_WORDS(STORE_WORDS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_bit_position (i_bit_position),
        .i_field_length (i_field_length),
        .i_deposit_value(i_deposit_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_field_value  (o_field_value),
        .o_range_error  (o_range_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Apply one load or deposit to the predicted vector and return its result
    function automatic t_field_result apply_field_op(t_cmd cmd, logic [POS_W-1:0] pos,
                                                     logic [LEN_W-1:0] len_in,
                                                     logic [WORD_BITS-1:0] value);
        int unsigned                     len;
        logic [STORE_BITS+WORD_BITS-1:0] padded;
        logic [WORD_BITS-1:0]            mask;
        t_field_result                   res;
        len = (len_in > WORD_BITS) ? WORD_BITS : len_in;
        mask = (len == WORD_BITS) ? '1 : ((64'd1 << len) - 64'd1);
        res = '0;
        if (cmd == CMD_DEPOSIT) deposits_sent++;
        else loads_sent++;
        if (pos + len > STORE_BITS) begin
            res.range_error = 1'b1;
            refused_sent++;
        end else if (len != 0) begin
            if ((pos % WORD_BITS) + len > WORD_BITS) straddles_sent++;
            if (cmd == CMD_DEPOSIT) begin
                for (int i = 0; i < len; i++) bit_vector[pos + i] = value[i];
            end else begin
                padded = {{WORD_BITS{1'b0}}, bit_vector};
                res.field_value = padded[pos +: WORD_BITS] & mask;
            end
        end
        return res;
    endfunction

    // Offer one transaction, hold it until accepted, then record its expected result
    task automatic send_item(t_cmd cmd, logic [POS_W-1:0] pos, logic [LEN_W-1:0] len,
                             logic [WORD_BITS-1:0] value);
        if (!sender_steady) begin
            while ($urandom_range(0, 99) < 33) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid         <= 1'b1;
        i_cmd           <= cmd;
        i_bit_position  <= pos;
        i_field_length  <= len;
        i_deposit_value <= value;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(apply_field_op(cmd, pos, len, value));
    endtask

    task automatic send_random_item();
        logic [POS_W-1:0] pos;
        logic [LEN_W-1:0] len;
        int unsigned      sel;
        // Lean on the top end of the vector now and then to reach the range check
        if ($urandom_range(0, 4) == 0) pos = POS_W'($urandom_range(LAST_WORD_POS, STORE_BITS - 1));
        else pos = POS_W'($urandom_range(0, STORE_BITS - 1));
        sel = $urandom_range(0, 19);
        if (sel < 2) len = LEN_W'(WORD_BITS);
        else if (sel < 4) len = LEN_W'($urandom_range(WORD_BITS + 1, (1 << LEN_W) - 1));
        else len = LEN_W'($urandom_range(0, WORD_BITS));
        send_item(t_cmd'($urandom_range(0, 1)), pos, len, {$urandom, $urandom});
    endtask

    // Check every result transaction against the oldest expectation and pace i_ready
    initial begin : result_side
        t_field_result want;
        int            hold;
        hold = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                results_checked++;
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("[%0t] result with nothing expected: value %h err %b",
                                 $realtime, o_field_value, o_range_error);
                end else begin
                    want = pending_results.pop_front();
                    if (o_field_value !== want.field_value ||
                        o_range_error !== want.range_error) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("[%0t] mismatch: expected value %h err %b, got %h err %b",
                                     $realtime, want.field_value, want.range_error,
                                     o_field_value, o_range_error);
                    end
                end
            end
            if (hold_request != 0) begin
                hold = hold_request;
                hold_request = 0;
            end
            if (hold != 0) begin
                hold--;
                i_ready <= 1'b0;
            end else if (receiver_steady) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= 33);
            end
        end
    end

    // Reset state: every field reads zero, including the last word
    task automatic test_reset_contents();
        send_item(CMD_LOAD, 0, LEN_W'(WORD_BITS), '1);
        send_item(CMD_LOAD, POS_W'(LAST_WORD_POS), LEN_W'(WORD_BITS), '0);
        send_item(CMD_LOAD, 517, 33, '0);
    endtask

    // Full-width fields, word-straddling fields and the single last bit
    task automatic test_full_and_straddle();
        send_item(CMD_DEPOSIT, 0, LEN_W'(WORD_BITS), '1);
        send_item(CMD_LOAD, 0, LEN_W'(WORD_BITS), '0);
        send_item(CMD_DEPOSIT, 37, LEN_W'(WORD_BITS), 64'hA5C3_0F96_1E2D_B478);
        send_item(CMD_LOAD, 37, LEN_W'(WORD_BITS), '0);
        send_item(CMD_LOAD, 60, 13, '0);
        send_item(CMD_DEPOSIT, 126, 5, 64'hFFFF_FFFF_FFFF_FFEA);
        send_item(CMD_LOAD, 120, 20, '0);
        send_item(CMD_DEPOSIT, POS_W'(STORE_BITS - 1), 1, 64'h1);
        send_item(CMD_LOAD, POS_W'(STORE_BITS - 1), 1, '0);
        send_item(CMD_LOAD, POS_W'(LAST_WORD_POS), LEN_W'(WORD_BITS), '0);
    endtask

    // Zero length reads zero and writes nothing, even at the last position
    task automatic test_zero_length();
        send_item(CMD_DEPOSIT, 0, 0, '1);
        send_item(CMD_LOAD, 0, 0, '0);
        send_item(CMD_LOAD, POS_W'(STORE_BITS - 1), 0, '0);
    endtask

    // Lengths above 64 saturate to a full word
    task automatic test_length_saturation();
        send_item(CMD_DEPOSIT, 200, LEN_W'((1 << LEN_W) - 1), 64'h0123_4567_89AB_CDEF);
        send_item(CMD_LOAD, 200, 100, '0);
        send_item(CMD_LOAD, 190, LEN_W'(WORD_BITS + 1), '0);
    endtask

    // Fields past the end are flagged, load zero and leave the store alone
    task automatic test_past_end();
        send_item(CMD_LOAD, POS_W'(LAST_WORD_POS + 1), LEN_W'(WORD_BITS), '0);
        send_item(CMD_DEPOSIT, 1000, 30, '1);
        send_item(CMD_LOAD, 1000, 24, '0);
        send_item(CMD_DEPOSIT, POS_W'(STORE_BITS - 1), LEN_W'((1 << LEN_W) - 1), '1);
    endtask

    task automatic test_random_traffic(int count);
        repeat (count) send_random_item();
    endtask

    // Stall the result side for a long stretch while items keep arriving
    task automatic test_back_pressure();
        sender_steady = 1'b1;
        hold_request = 300;
        repeat (40) send_random_item();
        sender_steady = 1'b0;
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_streaming(int count);
        sender_steady = 1'b1;
        receiver_steady = 1'b1;
        repeat (count) send_random_item();
        sender_steady = 1'b0;
        receiver_steady = 1'b0;
    endtask

    initial begin : main_sequence
        bit_vector      = '0;
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
        hold_request    = 0;
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_cmd           <= CMD_LOAD;
        i_bit_position  <= '0;
        i_field_length  <= '0;
        i_deposit_value <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_contents();
        test_full_and_straddle();
        test_zero_length();
        test_length_saturation();
        test_past_end();
        test_random_traffic(250);
        test_back_pressure();
        test_streaming(100);
        test_random_traffic(110);

        // Drain the pipeline, then keep the clock running to show any stray result
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Covered %0d loads and %0d deposits: %0d refused past the end, %0d straddling.",
                 loads_sent, deposits_sent, refused_sent, straddles_sent);
        $display("Checked %0d result transactions, %0d mismatches.",
                 results_checked, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("** bit_field_load_deposit_top: PASSED **");
        end else begin
            $display("** bit_field_load_deposit_top: FAILED **");
        end
        $finish;
    end

    // Watchdog for a hung handshake
    initial begin : watchdog
        #3000000;
        $display("Timed out with %0d results outstanding.", pending_results.size());
        $display("** bit_field_load_deposit_top: FAILED **");
        $finish;
    end

endmodule

// ===== bit_field_load_deposit_top.f =====
design/bfld_pkg.sv
design/bfld_bank.sv
design/bfld_field.sv
design/bit_field_load_deposit_top.sv
sim/tb.sv
